// File: hdl/landmark_map_associate_merge_assert.svh
// Assertion macros used by the landmark map top module.
// Each macro expects i_clk and i_rst_n in scope of the module that uses it.
`ifndef LANDMARK_MAP_ASSOCIATE_MERGE_ASSERT_SVH
`define LANDMARK_MAP_ASSOCIATE_MERGE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LMAM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lmam check failed");

// Next-cycle implication, checked outside reset.
`define LMAM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lmam check failed");

`endif

// File: hdl/lmam_pkg.sv
// Types, constants and small helpers for the landmark map block.
// No dependencies; used by lmam_dist and the top module of the block.
`default_nettype none
package lmam_pkg;
    localparam int CAP = 64;
    localparam int IDX_W = $clog2(CAP);
    localparam int CNT_W = $clog2(CAP + 1);
    localparam int INDEX_OUT_W = 6;
    localparam int COUNT_OUT_W = 7;
    localparam int POS_W = 20;
    localparam int DIST_W = 2 * (POS_W + 1) + 1;

    localparam logic [1:0] ST_MERGE = 2'd0;
    localparam logic [1:0] ST_NEW   = 2'd1;
    localparam logic [1:0] ST_DROP  = 2'd2;

    localparam logic [1:0] CFG_RADIUS  = 2'd0;
    localparam logic [1:0] CFG_CONFIRM = 2'd1;
    localparam logic [1:0] CFG_MAX_AGE = 2'd2;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [1:0]              color;
        logic [15:0]             hits;
        logic [31:0]             born;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Floor average of two coordinates; the result always fits.
    function automatic logic signed [POS_W-1:0] avg_floor(
        input logic signed [POS_W-1:0] a, input logic signed [POS_W-1:0] b);
        logic signed [POS_W:0] s;
        s = {a[POS_W-1], a} + {b[POS_W-1], b};
        return s[POS_W:1];
    endfunction

    function automatic logic [15:0] hits_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction
endpackage
`default_nettype wire

// File: hdl/lmam_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module lmam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: hdl/lmam_dist.sv
// Squared distance unit: registered squares, sum on the output.
// Depends on lmam_pkg.
`default_nettype none
module lmam_dist
    import lmam_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_load,
    input  wire logic signed [POS_W-1:0] i_ax,
    input  wire logic signed [POS_W-1:0] i_ay,
    input  wire logic signed [POS_W-1:0] i_bx,
    input  wire logic signed [POS_W-1:0] i_by,
    output logic [DIST_W-1:0]            o_dist
);
    logic signed [POS_W:0]     dx;
    logic signed [POS_W:0]     dy;
    logic signed [2*POS_W+1:0] sqx;
    logic signed [2*POS_W+1:0] sqy;
    logic [2*POS_W+1:0]        r_sqx;
    logic [2*POS_W+1:0]        r_sqy;

    assign dx  = {i_ax[POS_W-1], i_ax} - {i_bx[POS_W-1], i_bx};
    assign dy  = {i_ay[POS_W-1], i_ay} - {i_by[POS_W-1], i_by};
    assign sqx = dx * dx;
    assign sqy = dy * dy;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sqx <= sqx;
            r_sqy <= sqy;
        end
    end

    assign o_dist = {1'b0, r_sqx} + {1'b0, r_sqy};
endmodule
`default_nettype wire

// File: hdl/landmark_map_associate_merge.sv
// Landmark map with nearest-neighbor association, batch merge and pruning.
// Depends on lmam_pkg, lmam_ram, lmam_dist and the assertion macro header.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------------
//  in       | i_in_valid / o_in_ready    | i_pos_x i_pos_y i_color_code i_now_ms
//           |                            | i_last_of_batch
//  out      | o_out_valid / i_out_ready  | o_status o_entry_index o_entry_count
//  cfg      | i_cfg_we (no wait)         | i_cfg_idx i_cfg_data
//
// A detection word runs the nearest search over every valid entry (read, square,
// compare through the single RAM read port and squaring unit), then updates the
// table, a merge adding a read-modify-write state, and delivers the result.
// A batch-end word adds the pairwise merge over all entries and a compaction sweep.
// Reset is synchronous and active low; it clears control state and the entry
// count, neither RAM needs clearing. Only one word is in flight; the result
// register holds a finished word while the next one is accepted.
`default_nettype none
`include "landmark_map_associate_merge_assert.svh"
module landmark_map_associate_merge
    import lmam_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic signed [POS_W-1:0] i_pos_x,
    input  wire logic signed [POS_W-1:0] i_pos_y,
    input  wire logic [1:0]              i_color_code,
    input  wire logic [31:0]             i_now_ms,
    input  wire logic                    i_last_of_batch,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic [1:0]                   o_status,
    output logic [INDEX_OUT_W-1:0]       o_entry_index,
    output logic [COUNT_OUT_W-1:0]       o_entry_count,
    input  wire logic                    i_cfg_we,
    input  wire logic [1:0]              i_cfg_idx,
    input  wire logic [31:0]             i_cfg_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_SQ, S_CMP, S_DECIDE, S_MRD, S_POST,
        S_CI, S_CIW, S_CJ, S_CJSQ, S_CJCMP, S_CP, S_CPW, S_DONE
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [15:0] r_radius;
    logic [15:0] r_confirm;
    logic [31:0] r_max_age;

    // Current detection.
    logic signed [POS_W-1:0] r_px;
    logic signed [POS_W-1:0] r_py;
    logic [1:0]              r_col;
    logic [31:0]             r_now;
    logic                    r_last;
    logic [31:0]             r_gate;

    // Search and cleanup bookkeeping.
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_k;
    logic [CNT_W-1:0]  r_ci;
    logic [CNT_W-1:0]  r_wp;
    logic              r_found;
    logic [DIST_W-1:0] r_best;
    logic [IDX_W-1:0]  r_idx;
    t_entry            r_a;
    t_entry            r_b;

    // Result of the current word, captured before cleanup.
    logic [1:0]       r_res_status;
    logic [IDX_W-1:0] r_res_where;

    // RAM and distance unit hookup.
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry             rd_e;
    t_entry             wr_e;
    logic               dist_load;
    logic signed [POS_W-1:0] op_ax;
    logic signed [POS_W-1:0] op_ay;
    logic [DIST_W-1:0]  sq_sum;
    logic               in_acc;
    logic               gate_hit;
    logic               prune;

    // Removal flags for the cleanup pass. Every live entry below the count
    // holds a cleared flag: appends and the compaction sweep write it.
    logic               gone_we;
    logic [IDX_W-1:0]   gone_waddr;
    logic               gone_wdata;
    logic               gone_rd;

    assign rd_e      = t_entry'(ram_rdata);
    assign ram_wdata = ENTRY_W'(wr_e);
    assign in_acc    = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign gate_hit  = sq_sum < DIST_W'(r_gate);
    assign prune     = (rd_e.hits < r_confirm) && ((r_now - rd_e.born) > r_max_age);

    lmam_ram #(.WIDTH(ENTRY_W), .DEPTH(CAP)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The flag memory is read at the same address as the entry memory.
    lmam_ram #(.WIDTH(1), .DEPTH(CAP)) u_gone (
        .i_clk   (i_clk),
        .i_we    (gone_we),
        .i_waddr (gone_waddr),
        .i_wdata (gone_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (gone_rd)
    );

    lmam_dist u_dist (
        .i_clk  (i_clk),
        .i_load (dist_load),
        .i_ax   (op_ax),
        .i_ay   (op_ay),
        .i_bx   (rd_e.x),
        .i_by   (rd_e.y),
        .o_dist (sq_sum)
    );

    // Memory port and distance unit control, decoded from the state.
    always_comb begin
        ram_we     = 1'b0;
        ram_waddr  = r_idx;
        wr_e       = r_a;
        ram_raddr  = r_k[IDX_W-1:0];
        gone_we    = 1'b0;
        gone_waddr = r_k[IDX_W-1:0];
        gone_wdata = 1'b0;
        dist_load  = 1'b0;
        op_ax      = r_px;
        op_ay      = r_py;
        unique case (r_state)
            S_DECIDE: begin
                ram_raddr = r_idx;
                if (!(r_found && r_best < DIST_W'(r_gate)) && r_count < CNT_W'(CAP)) begin
                    ram_we     = 1'b1;
                    ram_waddr  = r_count[IDX_W-1:0];
                    wr_e.x     = r_px;
                    wr_e.y     = r_py;
                    wr_e.color = r_col;
                    wr_e.hits  = 16'd1;
                    wr_e.born  = r_now;
                    gone_we    = 1'b1;
                    gone_waddr = r_count[IDX_W-1:0];
                end
            end
            S_MRD: begin
                // Merge the detection into the matched entry.
                ram_we     = 1'b1;
                ram_waddr  = r_idx;
                wr_e       = rd_e;
                wr_e.x     = avg_floor(rd_e.x, r_px);
                wr_e.y     = avg_floor(rd_e.y, r_py);
                wr_e.hits  = hits_add(rd_e.hits, 16'd1);
            end
            S_SQ: dist_load = 1'b1;
            S_CI: ram_raddr = r_ci[IDX_W-1:0];
            S_CJ: begin
                ram_raddr = r_k[IDX_W-1:0];
                if (r_k == r_count) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_ci[IDX_W-1:0];
                end
            end
            S_CJSQ: begin
                dist_load = !gone_rd;
                op_ax     = r_a.x;
                op_ay     = r_a.y;
            end
            S_CJCMP: begin
                if (gate_hit) begin
                    gone_we    = 1'b1;
                    gone_wdata = 1'b1;
                end
            end
            S_CPW: begin
                ram_we     = !prune && !gone_rd;
                ram_waddr  = r_wp[IDX_W-1:0];
                wr_e       = rd_e;
                gone_we    = !prune && !gone_rd;
                gone_waddr = r_wp[IDX_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_radius    <= 16'd77;
            r_confirm   <= 16'd12;
            r_max_age   <= 32'd2000;
            r_count     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_RADIUS:  r_radius  <= i_cfg_data[15:0];
                    CFG_CONFIRM: r_confirm <= i_cfg_data[15:0];
                    CFG_MAX_AGE: r_max_age <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            // The done state loads the next word itself when the old one leaves.
            if (o_out_valid && i_out_ready && r_state != S_DONE) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_px    <= i_pos_x;
                        r_py    <= i_pos_y;
                        r_col   <= i_color_code;
                        r_now   <= i_now_ms;
                        r_last  <= i_last_of_batch;
                        r_gate  <= 32'(r_radius) * 32'(r_radius);
                        r_found <= 1'b0;
                        r_idx   <= '0;
                        r_k     <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: r_state <= (r_k == r_count) ? S_DECIDE : S_SQ;
                S_SQ:   r_state <= S_CMP;
                S_CMP: begin
                    // Strict compare keeps the lowest position on ties.
                    if (!r_found || sq_sum < r_best) begin
                        r_best  <= sq_sum;
                        r_idx   <= r_k[IDX_W-1:0];
                        r_found <= 1'b1;
                    end
                    r_k     <= CNT_W'(r_k + 1'b1);
                    r_state <= S_SCAN;
                end
                S_DECIDE: begin
                    if (r_found && r_best < DIST_W'(r_gate)) begin
                        r_res_status <= ST_MERGE;
                        r_res_where  <= r_idx;
                        r_state      <= S_MRD;
                    end else if (r_count < CNT_W'(CAP)) begin
                        r_res_status <= ST_NEW;
                        r_res_where  <= r_count[IDX_W-1:0];
                        r_count      <= CNT_W'(r_count + 1'b1);
                        r_state      <= S_POST;
                    end else begin
                        r_res_status <= ST_DROP;
                        r_res_where  <= '0;
                        r_state      <= S_POST;
                    end
                end
                S_MRD: r_state <= S_POST;
                S_POST: begin
                    r_ci    <= '0;
                    r_state <= r_last ? S_CI : S_DONE;
                end
                S_CI: begin
                    if (r_ci == r_count) begin
                        r_k     <= '0;
                        r_wp    <= '0;
                        r_state <= S_CP;
                    end else begin
                        r_state <= S_CIW;
                    end
                end
                S_CIW: begin
                    // A removed entry starts no row.
                    if (gone_rd) begin
                        r_ci    <= CNT_W'(r_ci + 1'b1);
                        r_state <= S_CI;
                    end else begin
                        r_a     <= rd_e;
                        r_k     <= CNT_W'(r_ci + 1'b1);
                        r_state <= S_CJ;
                    end
                end
                S_CJ: begin
                    // At the end of the row the held entry is written back.
                    if (r_k == r_count) begin
                        r_ci    <= CNT_W'(r_ci + 1'b1);
                        r_state <= S_CI;
                    end else begin
                        r_state <= S_CJSQ;
                    end
                end
                S_CJSQ: begin
                    if (gone_rd) begin
                        r_k     <= CNT_W'(r_k + 1'b1);
                        r_state <= S_CJ;
                    end else begin
                        r_b     <= rd_e;
                        r_state <= S_CJCMP;
                    end
                end
                S_CJCMP: begin
                    if (gate_hit) begin
                        r_a.x    <= avg_floor(r_a.x, r_b.x);
                        r_a.y    <= avg_floor(r_a.y, r_b.y);
                        r_a.hits <= hits_add(r_a.hits, r_b.hits);
                        if (!(r_a.hits > r_b.hits)) begin
                            r_a.color <= r_b.color;
                        end
                    end
                    r_k     <= CNT_W'(r_k + 1'b1);
                    r_state <= S_CJ;
                end
                S_CP: begin
                    if (r_k == r_count) begin
                        r_count <= r_wp;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_CPW;
                    end
                end
                S_CPW: begin
                    if (!prune && !gone_rd) begin
                        r_wp <= CNT_W'(r_wp + 1'b1);
                    end
                    r_k     <= CNT_W'(r_k + 1'b1);
                    r_state <= S_CP;
                end
                S_DONE: begin
                    if (!o_out_valid || i_out_ready) begin
                        o_out_valid   <= 1'b1;
                        o_status      <= r_res_status;
                        o_entry_index <= INDEX_OUT_W'(r_res_where);
                        o_entry_count <= COUNT_OUT_W'(r_count);
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `LMAM_ASSERT_IMP(a_count_cap, 1'b1, r_count <= CNT_W'(CAP))
    `LMAM_ASSERT_NXT(a_busy_after_accept, in_acc, !o_in_ready)
    `LMAM_ASSERT_IMP(a_compact_behind, r_state == S_CP || r_state == S_CPW, r_wp <= r_k)
    `LMAM_ASSERT_IMP(a_idle_count_stable, r_state == S_IDLE && $past(r_state == S_IDLE),
        $stable(r_count))
endmodule
`default_nettype wire
